[hw/rtl/atdp_pkg.sv]
// Shared types and constants for the ASCII three-axis decimal parser.
// Used by atdp_core and ascii_three_axis_decimal_parser_top; no dependencies.
`default_nettype none

package atdp_pkg;

    localparam int LINE_LIMIT_DEFAULT = 25;

    localparam int CHAR_W  = 8;
    localparam int AXIS_W  = 2;
    localparam int VALUE_W = 18;
    localparam int MAG_W   = 17;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'd61;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'd46;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_X    = 2'd1,
        PH_Y    = 2'd2,
        PH_Z    = 2'd3
    } phase_t;

    typedef struct packed {
        logic                       valid;
        logic [AXIS_W-1:0]          axis;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } atdp_result_t;

endpackage

`default_nettype wire

[hw/rtl/atdp_core.sv]
// Parser state and per-beat update: phase, sign, decimal digits, line position.
// Depends on atdp_pkg.
`default_nettype none

module atdp_core
    import atdp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [CHAR_W-1:0]  char_in,
    output atdp_result_t            result
);

    localparam int POS_W = $clog2(LINE_LIMIT + 1);

    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic                 frac_reg, frac_next;
    logic                 fseen_reg, fseen_next;
    logic [DIGIT_W-1:0]   int2_reg, int2_next;
    logic [DIGIT_W-1:0]   int1_reg, int1_next;
    logic [DIGIT_W-1:0]   int0_reg, int0_next;
    logic [DIGIT_W-1:0]   frac1_reg, frac1_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    logic                 at_limit;
    logic                 emit;
    logic [MAG_W-1:0]     magnitude;

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign digit    = DIGIT_W'(char_in - CH_ZERO);
    assign at_limit = (pos_reg >= POS_W'(LINE_LIMIT));
    assign emit     = (char_in != CH_NEWLINE) && !at_limit && (char_in != CH_EQUALS)
                      && (phase_reg != PH_WAIT) && frac_reg && is_digit && fseen_reg;

    assign magnitude = MAG_W'(int2_reg) * MAG_W'(10000) + MAG_W'(int1_reg) * MAG_W'(1000)
                     + MAG_W'(int0_reg) * MAG_W'(100) + MAG_W'(frac1_reg) * MAG_W'(10)
                     + MAG_W'(digit);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        frac_next  = frac_reg;
        fseen_next = fseen_reg;
        int2_next  = int2_reg;
        int1_next  = int1_reg;
        int0_next  = int0_reg;
        frac1_next = frac1_reg;
        pos_next   = pos_reg;
        if (char_in == CH_NEWLINE) begin
            phase_next = PH_WAIT;
            pos_next   = '0;
            neg_next   = 1'b0;
            frac_next  = 1'b0;
            fseen_next = 1'b0;
            int2_next  = '0;
            int1_next  = '0;
            int0_next  = '0;
            frac1_next = '0;
        end else if (!at_limit) begin
            pos_next = pos_reg + 1'b1;
            if (char_in == CH_EQUALS) begin
                phase_next = PH_X;
                neg_next   = 1'b0;
                frac_next  = 1'b0;
                fseen_next = 1'b0;
                int2_next  = '0;
                int1_next  = '0;
                int0_next  = '0;
                frac1_next = '0;
            end else if (phase_reg != PH_WAIT) begin
                if (!frac_reg) begin
                    if (char_in == CH_MINUS) begin
                        neg_next = 1'b1;
                    end else if (char_in == CH_DOT) begin
                        frac_next = 1'b1;
                    end else if (is_digit) begin
                        int2_next = int1_reg;
                        int1_next = int0_reg;
                        int0_next = digit;
                    end
                end else if (is_digit) begin
                    if (!fseen_reg) begin
                        fseen_next = 1'b1;
                        frac1_next = digit;
                    end else begin
                        case (phase_reg)
                            PH_X:    phase_next = PH_Y;
                            PH_Y:    phase_next = PH_Z;
                            default: phase_next = PH_WAIT;
                        endcase
                        neg_next   = 1'b0;
                        frac_next  = 1'b0;
                        fseen_next = 1'b0;
                        int2_next  = '0;
                        int1_next  = '0;
                        int0_next  = '0;
                        frac1_next = '0;
                    end
                end
            end
        end
    end

    always_comb begin
        result.valid = emit;
        result.last  = (phase_reg == PH_Z);
        result.value = neg_reg ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
        case (phase_reg)
            PH_X:    result.axis = AXIS_X;
            PH_Y:    result.axis = AXIS_Y;
            default: result.axis = AXIS_Z;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            neg_reg   <= 1'b0;
            frac_reg  <= 1'b0;
            fseen_reg <= 1'b0;
            int2_reg  <= '0;
            int1_reg  <= '0;
            int0_reg  <= '0;
            frac1_reg <= '0;
            pos_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            frac_reg  <= frac_next;
            fseen_reg <= fseen_next;
            int2_reg  <= int2_next;
            int1_reg  <= int1_next;
            int0_reg  <= int0_next;
            frac1_reg <= frac1_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ascii_three_axis_decimal_parser_top.sv]
// Top level: input beat register, parser core, result register.
// Depends on atdp_pkg and atdp_core.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   s_      | s_valid s_ready s_char_in               | in
//   m_      | m_valid m_ready m_axis m_value_hundredths m_last | out
//
// One beat per cycle unless results stall; bytes pass both registers to m_.
// The parser state updates once per beat as it moves from the input register.
// Synchronous active-low reset clears the parser; no clearing pass.
// A stalled result holds the input register; s_ready drops only while both
// registers are full and the waiting byte would produce a result.
`default_nettype none

module ascii_three_axis_decimal_parser_top
    import atdp_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic [CHAR_W-1:0]          s_char_in,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic [AXIS_W-1:0]          m_axis,
    output      logic signed [VALUE_W-1:0]  m_value_hundredths,
    output      logic                       m_last
);

    logic                       in_valid_reg;
    logic [CHAR_W-1:0]          in_char_reg;
    logic                       out_valid_reg;
    logic [AXIS_W-1:0]          out_axis_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic                       out_last_reg;

    atdp_result_t               res;
    logic                       out_free;
    logic                       advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign s_ready  = !in_valid_reg || advance;

    atdp_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .char_in (in_char_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res.valid) begin
            out_axis_reg  <= res.axis;
            out_value_reg <= res.value;
            out_last_reg  <= res.last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_axis             = out_axis_reg;
    assign m_value_hundredths = out_value_reg;
    assign m_last             = out_last_reg;

`ifndef SYNTHESIS
    a_last_is_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_axis == AXIS_Z)))
        else $error("last flag does not match z axis");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_axis != 2'd3))
        else $error("axis code out of range");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_value_hundredths <= 18'sd99999)
                     && (m_value_hundredths >= -18'sd99999)))
        else $error("value out of range");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.valid) |=> m_valid)
        else $error("produced result not registered");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without full result register");
`endif

endmodule

`default_nettype wire

[verif/ascii_three_axis_decimal_parser_top_tb.sv]
// Self-checking testbench for ascii_three_axis_decimal_parser_top: sensor text lines in,
// parsed x/y/z readings in hundredths out, checked against a predictor in the bench.
// Depends on atdp_pkg and the parser RTL only.
module ascii_three_axis_decimal_parser_top_tb;
    import atdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam int TARGET_BEATS = 1440;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [AXIS_W-1:0]         axis;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } reading_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        bit                drain;
    } beat_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [CHAR_W-1:0]         s_char_in = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [AXIS_W-1:0]         m_axis;
    logic signed [VALUE_W-1:0] m_value_hundredths;
    logic                      m_last;

    beat_t             pending_beats[$];
    beat_t             drv_beat;
    logic [CHAR_W-1:0] line_buf[$];
    reading_t          expected_readings[$];
    reading_t          got;
    reading_t          want;
    bit                drained = 1'b0;
    int                mismatches = 0;
    int                beats_offered = 0;
    int                stall_cycles = 0;

    // predictor state
    phase_t            prs_phase = PH_WAIT;
    logic              prs_neg = 1'b0;
    logic [MAG_W-1:0]  prs_mag = '0;
    logic [1:0]        prs_frac = '0;
    logic              prs_in_frac = 1'b0;
    int                prs_pos = 0;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int holdoff_left = 0;
    int holdoffs_done = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int rx_tick = 0;

    ascii_three_axis_decimal_parser_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_in          (s_char_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_axis             (m_axis),
        .m_value_hundredths (m_value_hundredths),
        .m_last             (m_last)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void clear_number();
        prs_neg = 1'b0;
        prs_mag = '0;
        prs_frac = '0;
        prs_in_frac = 1'b0;
    endfunction

    function automatic void reset_parser();
        prs_phase = PH_WAIT;
        prs_pos = 0;
        clear_number();
    endfunction

    function automatic bit parse_byte(input logic [CHAR_W-1:0] c, output reading_t r);
        bit is_digit;
        int digit;
        int mag;
        r = '0;
        if (c == CH_NEWLINE) begin
            reset_parser();
            return 1'b0;
        end
        if (prs_pos >= LINE_LIMIT_DEFAULT) return 1'b0;
        prs_pos++;
        if (c == CH_EQUALS) begin
            prs_phase = PH_X;
            clear_number();
            return 1'b0;
        end
        if (prs_phase == PH_WAIT) return 1'b0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        digit = is_digit ? int'(c - CH_ZERO) : 0;
        mag = int'(prs_mag);
        if (!prs_in_frac) begin
            if (c == CH_MINUS) prs_neg = 1'b1;
            else if (c == CH_DOT) prs_in_frac = 1'b1;
            else if (is_digit) prs_mag = MAG_W'((mag * 10 + digit) % 1000);
            return 1'b0;
        end
        if (!is_digit) return 1'b0;
        prs_mag = MAG_W'(mag * 10 + digit);
        prs_frac++;
        if (prs_frac < 2) return 1'b0;
        r.value = prs_neg ? -$signed({1'b0, prs_mag}) : $signed({1'b0, prs_mag});
        r.last = (prs_phase == PH_Z);
        case (prs_phase)
            PH_X: begin
                r.axis = AXIS_X;
                prs_phase = PH_Y;
            end
            PH_Y: begin
                r.axis = AXIS_Y;
                prs_phase = PH_Z;
            end
            default: begin
                r.axis = AXIS_Z;
                prs_phase = PH_WAIT;
            end
        endcase
        clear_number();
        return 1'b1;
    endfunction

    function automatic void put(input logic [CHAR_W-1:0] b);
        line_buf.push_back(b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic void flush_line(input bit drain_first);
        beat_t b;
        for (int i = 0; i < line_buf.size(); i++) begin
            b.ch = line_buf[i];
            b.drain = drain_first && (i == 0);
            pending_beats.push_back(b);
        end
        line_buf.delete();
    endfunction

    function automatic void put_number(input bit short_form);
        int n_int;
        bit all_nines;
        all_nines = ($urandom_range(0, 7) == 0);
        if (!short_form && $urandom_range(0, 2) == 0) put(CH_MINUS);
        n_int = $urandom_range(1, 3);
        if (short_form) n_int = 1;
        else if ($urandom_range(0, 9) == 0) n_int = 0;
        else if ($urandom_range(0, 9) == 0) n_int = $urandom_range(4, 5);
        repeat (n_int) put(all_nines ? CH_NINE : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        put(CH_DOT);
        repeat (2) put(all_nines ? CH_NINE : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endfunction

    function automatic void add_sensor_line(input bit drain_first);
        int kind;
        int idx;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            repeat ($urandom_range(1, 30)) put(CHAR_W'($urandom_range(0, 255)));
        end else if (kind < 4) begin
            repeat (2) begin
                put(CH_EQUALS);
                for (int a = 0; a < 3; a++) begin
                    put_number(1'b1);
                    if (a < 2) put(CH_COMMA);
                end
            end
        end else begin
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 4)) put(CH_UPPER_A + CHAR_W'($urandom_range(0, 25)));
            put(CH_EQUALS);
            for (int a = 0; a < 3; a++) begin
                put_number(1'b0);
                if (a < 2) put(CH_COMMA);
                if (a < 2 && $urandom_range(0, 4) == 0) put(CH_SPACE);
            end
            if (kind >= 16) begin
                idx = $urandom_range(0, line_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: line_buf[idx] = CHAR_W'($urandom_range(0, 255));
                    1: line_buf.delete(idx);
                    default: line_buf.insert(idx, CH_EQUALS);
                endcase
            end
        end
        if ($urandom_range(0, 15) != 0) put(CH_NEWLINE);
        flush_line(drain_first);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_char_in <= '0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() > 0 &&
                         (!pending_beats[0].drain || (!s_valid && drained))) begin
                drv_beat = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_char_in <= drv_beat.ch;
                beats_offered <= beats_offered + 1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else if (holdoffs_done < 2 &&
                     beats_offered >= (holdoffs_done == 0 ? 350 : 1000)) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoffs_done++;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            rx_tick++;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    always @(negedge aclk) begin
        drained <= (expected_readings.size() == 0);
    end

    // monitor: predict on input beats, compare on result beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
        end else begin
            if (s_valid && s_ready) begin
                if (parse_byte(s_char_in, got)) expected_readings.push_back(got);
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: axis %0d value %0d last %0d",
                                 m_axis, m_value_hundredths, m_last);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_axis !== want.axis || m_value_hundredths !== want.value ||
                        m_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: expected axis %0d value %0d last %0d, got %0d %0d %0d",
                                     want.axis, want.value, want.last,
                                     m_axis, m_value_hundredths, m_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        bit mid_drain_done;
        mid_drain_done = 1'b0;
        put(8'h00);
        put(8'hFF);
        put_text("=-0.00,999.99,.7-.8");
        put(CH_NEWLINE);
        flush_line(1'b0);
        add_sensor_line(1'b1);
        while (pending_beats.size() < TARGET_BEATS) begin
            if (!mid_drain_done && pending_beats.size() >= 800) begin
                add_sensor_line(1'b1);
                mid_drain_done = 1'b1;
            end else begin
                add_sensor_line(1'b0);
            end
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_readings.size() != 0);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
